@@ sv/tun_pkg.sv @@
// Shared types and constants for the triangle unit normal pipeline.
// No dependencies.
package tun_pkg;

  localparam int WORK_BITS  = 30;
  localparam int OUT_WIDTH  = 16;
  localparam int SUM_WIDTH  = 2 * WORK_BITS + 2;
  localparam int ROOT_WIDTH = SUM_WIDTH / 2;

  // side-band that travels with every word through the pipeline
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_meta_t;

endpackage

@@ sv/tun_front.sv @@
// Edge vectors, cross product and component magnitudes (three stages).
// Depends on tun_pkg.
module tun_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [2:0][COORD_WIDTH-1:0]         va_i,
  input  logic [2:0][COORD_WIDTH-1:0]         vb_i,
  input  logic [2:0][COORD_WIDTH-1:0]         vc_i,
  output logic [2:0][2*COORD_WIDTH+2:0]       mag_o,
  output tun_pkg::tun_meta_t                  meta_o
);
  import tun_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [PW-1:0] p_q  [6];
  logic [2:0][CW-1:0]   mag_q;
  logic [2:0]           neg_q;
  logic [1:0]           vld_q;
  logic                 vld3_q;

  // stage 1: exact differences b-a and c-a
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= $signed({vb_i[i][COORD_WIDTH-1], vb_i[i]})
               - $signed({va_i[i][COORD_WIDTH-1], va_i[i]});
      d2_q[i] <= $signed({vc_i[i][COORD_WIDTH-1], vc_i[i]})
               - $signed({va_i[i][COORD_WIDTH-1], va_i[i]});
    end
  end

  // stage 2: six partial products
  always_ff @(posedge clk_i) begin
    p_q[0] <= d1_q[1] * d2_q[2];
    p_q[1] <= d1_q[2] * d2_q[1];
    p_q[2] <= d1_q[2] * d2_q[0];
    p_q[3] <= d1_q[0] * d2_q[2];
    p_q[4] <= d1_q[0] * d2_q[1];
    p_q[5] <= d1_q[1] * d2_q[0];
  end

  // stage 3: cross product, split into sign and magnitude
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] cr;
    for (int i = 0; i < 3; i++) begin
      cr = $signed({p_q[2*i][PW-1], p_q[2*i]})
         - $signed({p_q[2*i+1][PW-1], p_q[2*i+1]});
      neg_q[i] <= cr[CW-1];
      mag_q[i] <= cr[CW-1] ? CW'(-cr) : CW'(cr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vld3_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[0], valid_i};
      vld3_q <= vld_q[1];
    end
  end

  assign mag_o        = mag_q;
  assign meta_o.valid = vld3_q;
  assign meta_o.degen = 1'b0;
  assign meta_o.neg   = neg_q;

endmodule

@@ sv/tun_norm.sv @@
// Leading-zero count, normalising shift, squares and their sum (four stages).
// Depends on tun_pkg.
module tun_norm #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0][2*COORD_WIDTH+2:0]  mag_i,
  input  tun_pkg::tun_meta_t             meta_i,
  output logic [2:0][tun_pkg::WORK_BITS-1:0] sm_o,
  output logic [tun_pkg::SUM_WIDTH-1:0]  sum_o,
  output tun_pkg::tun_meta_t             meta_o
);
  import tun_pkg::*;

  localparam int CW  = 2 * COORD_WIDTH + 3;
  localparam int LZW = $clog2(CW + 1);

  function automatic logic [LZW-1:0] lead_zeros(input logic [CW-1:0] v);
    logic [LZW-1:0] n;
    n = LZW'(CW);
    for (int i = 0; i < CW; i++) begin
      if (v[i]) n = LZW'(CW - 1 - i);
    end
    return n;
  endfunction

  logic [2:0][CW-1:0]        mag4_q;
  logic [LZW-1:0]            lz_q;
  logic [2:0][WORK_BITS-1:0] sm5_q, sm6_q, sm7_q;
  logic [2:0][WORK_BITS-1:0] sm5_d;
  logic [2:0][2*WORK_BITS-1:0] sq_q;
  logic [SUM_WIDTH-1:0]      sum_q;
  tun_meta_t                 m4_q, m5_q, m6_q, m7_q;

  // stage 4: position of the leading one across all three magnitudes
  always_ff @(posedge clk_i) begin
    mag4_q <= mag_i;
    lz_q   <= lead_zeros(mag_i[0] | mag_i[1] | mag_i[2]);
  end

  // stage 5: bring the largest magnitude to the top of the working word
  always_comb begin
    logic [CW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      t = mag4_q[i] << lz_q;
      if (CW >= WORK_BITS) sm5_d[i] = WORK_BITS'(t >> (CW - WORK_BITS));
      else                 sm5_d[i] = WORK_BITS'({t, {WORK_BITS{1'b0}}} >> CW);
    end
  end

  always_ff @(posedge clk_i) begin
    sm5_q <= sm5_d;
    // stage 6
    sm6_q <= sm5_q;
    for (int i = 0; i < 3; i++) sq_q[i] <= sm5_q[i] * sm5_q[i];
    // stage 7
    sm7_q <= sm6_q;
    sum_q <= SUM_WIDTH'(sq_q[0]) + SUM_WIDTH'(sq_q[1]) + SUM_WIDTH'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m4_q <= '0;
      m5_q <= '0;
      m6_q <= '0;
      m7_q <= '0;
    end else begin
      m4_q <= '{valid: meta_i.valid,
                degen: ~|(mag_i[0] | mag_i[1] | mag_i[2]),
                neg:   meta_i.neg};
      m5_q <= m4_q;
      m6_q <= m5_q;
      m7_q <= m6_q;
    end
  end

  assign sm_o   = sm7_q;
  assign sum_o  = sum_q;
  assign meta_o = m7_q;

endmodule

@@ sv/tun_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on tun_pkg.
module tun_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tun_pkg::SUM_WIDTH-1:0]      sum_i,
  input  logic [2:0][tun_pkg::WORK_BITS-1:0] sm_i,
  input  tun_pkg::tun_meta_t                 meta_i,
  output logic [tun_pkg::ROOT_WIDTH-1:0]     root_o,
  output logic [2:0][tun_pkg::WORK_BITS-1:0] sm_o,
  output tun_pkg::tun_meta_t                 meta_o
);
  import tun_pkg::*;

  localparam int RB = ROOT_WIDTH;
  localparam int RW = ROOT_WIDTH + 3;

  logic [RW-1:0]             rem_q  [RB];
  logic [RB-1:0]             root_q [RB];
  logic [SUM_WIDTH-1:0]      rad_q  [RB];
  logic [2:0][WORK_BITS-1:0] sm_q   [RB];
  tun_meta_t                 m_q    [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [RW-1:0]             rem_in, rem_d, trial;
    logic [RB-1:0]             root_in, root_d;
    logic [SUM_WIDTH-1:0]      rad_in;
    logic [2:0][WORK_BITS-1:0] sm_in;
    tun_meta_t                 m_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_i;
      assign sm_in   = sm_i;
      assign m_in    = meta_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sm_in   = sm_q[k-1];
      assign m_in    = m_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rem_d  = {rem_in[RW-3:0], rad_in[SUM_WIDTH-1 -: 2]};
      trial  = RW'({root_in, 2'b01});
      root_d = {root_in[RB-2:0], 1'b0};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_in[RB-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      rad_q[k]  <= rad_in << 2;
      sm_q[k]   <= sm_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) m_q[k] <= '0;
      else         m_q[k] <= m_in;
    end
  end

  assign root_o = root_q[RB-1];
  assign sm_o   = sm_q[RB-1];
  assign meta_o = m_q[RB-1];

endmodule

@@ sv/tun_div.sv @@
// Three-lane pipelined restoring divider with rounding, cap, sign and output stage.
// Depends on tun_pkg.
module tun_div #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tun_pkg::ROOT_WIDTH-1:0]      root_i,
  input  logic [2:0][tun_pkg::WORK_BITS-1:0]  sm_i,
  input  tun_pkg::tun_meta_t                  meta_i,
  output logic [2:0][tun_pkg::OUT_WIDTH-1:0]  nrm_o,
  output logic                                degen_o,
  output logic                                valid_o
);
  import tun_pkg::*;

  localparam int QB  = NORMAL_FRAC_BITS + 1;
  localparam int NW  = WORK_BITS + QB + 1;
  localparam int DVW = ROOT_WIDTH + 1;
  localparam int RMW = DVW + 1;
  localparam int XW  = (QB > OUT_WIDTH) ? QB + 1 : OUT_WIDTH + 1;

  logic [2:0][RMW-1:0] rem_q  [QB];
  logic [2:0][NW-1:0]  num_q  [QB];
  logic [2:0][QB-1:0]  quo_q  [QB];
  logic [DVW-1:0]      dv_q   [QB];
  tun_meta_t           m_q    [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [2:0][RMW-1:0] rem_in, rem_d;
    logic [2:0][NW-1:0]  num_in;
    logic [2:0][QB-1:0]  quo_in, quo_d;
    logic [DVW-1:0]      dv_in;
    tun_meta_t           m_in;

    if (k == 0) begin : g_first
      assign dv_in = {root_i, 1'b0};
      assign m_in  = meta_i;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        // numerator 2*sm*2^F + L, so the quotient is rounded to nearest
        assign num_in[l] = (NW'(sm_i[l]) << QB) + NW'(root_i);
        assign rem_in[l] = RMW'(num_in[l] >> QB);
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign dv_in  = dv_q[k-1];
      assign m_in   = m_q[k-1];
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_d[l] = {rem_in[l][RMW-2:0], num_in[l][QB-1-k]};
        quo_d[l] = {quo_in[l][QB-2:0], 1'b0};
        if (rem_d[l] >= RMW'(dv_in)) begin
          rem_d[l] = rem_d[l] - RMW'(dv_in);
          quo_d[l] = {quo_in[l][QB-2:0], 1'b1};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      num_q[k] <= num_in;
      quo_q[k] <= quo_d;
      dv_q[k]  <= dv_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) m_q[k] <= '0;
      else         m_q[k] <= m_in;
    end
  end

  // output stage: cap at one, apply sign, zero a degenerate normal
  logic [2:0][OUT_WIDTH-1:0] nrm_q, nrm_d;
  logic                      degen_q, valid_q;

  always_comb begin
    logic [XW-1:0] qx;
    for (int l = 0; l < 3; l++) begin
      qx = XW'(quo_q[QB-1][l]);
      if (qx > (XW'(1) << NORMAL_FRAC_BITS)) qx = XW'(1) << NORMAL_FRAC_BITS;
      if (m_q[QB-1].neg[l]) qx = -qx;
      nrm_d[l] = m_q[QB-1].degen ? '0 : qx[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q <= nrm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      degen_q <= 1'b0;
    end else begin
      valid_q <= m_q[QB-1].valid;
      degen_q <= m_q[QB-1].valid & m_q[QB-1].degen;
    end
  end

  assign nrm_o   = nrm_q;
  assign degen_o = degen_q;
  assign valid_o = valid_q;

endmodule

@@ sv/triangle_unit_normal.sv @@
// Top level of the triangle unit normal pipeline.
// Depends on tun_pkg, tun_front, tun_norm, tun_sqrt and tun_div.
//
// Usage
//   Drive the nine vertex coordinates (signed, COORD_WIDTH bits) with start
//   high; the word is taken at the rising edge where start is high and busy
//   is low. busy never rises: the pipeline takes one triangle every cycle.
//   Each normal appears on nrm_x_o/nrm_y_o/nrm_z_o/degenerate_o for exactly one
//   cycle with done_o high. Results leave in the order triangles entered.
//   The chain has 3 stages for the cross product, 4 for the normalising
//   shift and sum of squares, 31 for the square root (one root bit per stage)
//   and NORMAL_FRAC_BITS + 1 for the three-lane divider (one quotient bit per
//   stage), plus one output register.
//   Throughput is one triangle per cycle, sustained.
//   A zero cross product gives a zero normal with degenerate_o high.
//   Reset clears every valid bit at once, so nothing is delivered for words
//   in flight when reset falls. The receiver has no back-pressure: drop
//   nothing, hold nothing, every word simply advances one stage per cycle.
module triangle_unit_normal #(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_WIDTH-1:0]          ax_i,
  input  logic [COORD_WIDTH-1:0]          ay_i,
  input  logic [COORD_WIDTH-1:0]          az_i,
  input  logic [COORD_WIDTH-1:0]          bx_i,
  input  logic [COORD_WIDTH-1:0]          by_coord_i,
  input  logic [COORD_WIDTH-1:0]          bz_i,
  input  logic [COORD_WIDTH-1:0]          cx_i,
  input  logic [COORD_WIDTH-1:0]          cy_i,
  input  logic [COORD_WIDTH-1:0]          cz_i,
  output logic                            done_o,
  output logic [tun_pkg::OUT_WIDTH-1:0]   nrm_x_o,
  output logic [tun_pkg::OUT_WIDTH-1:0]   nrm_y_o,
  output logic [tun_pkg::OUT_WIDTH-1:0]   nrm_z_o,
  output logic                            degenerate_o
);
  import tun_pkg::*;

  localparam int CW = 2 * COORD_WIDTH + 3;

  tun_meta_t                 front_meta, norm_meta, sqrt_meta;
  logic [2:0][CW-1:0]        mag;
  logic [2:0][WORK_BITS-1:0] sm_norm, sm_sqrt;
  logic [SUM_WIDTH-1:0]      sum;
  logic [ROOT_WIDTH-1:0]     root;
  logic [2:0][OUT_WIDTH-1:0] nrm;

  // the pipeline never holds a word back
  assign busy = 1'b0;

  tun_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .va_i    ({az_i, ay_i, ax_i}),
    .vb_i    ({bz_i, by_coord_i, bx_i}),
    .vc_i    ({cz_i, cy_i, cx_i}),
    .mag_o   (mag),
    .meta_o  (front_meta)
  );

  tun_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mag_i  (mag),
    .meta_i (front_meta),
    .sm_o   (sm_norm),
    .sum_o  (sum),
    .meta_o (norm_meta)
  );

  tun_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sum_i  (sum),
    .sm_i   (sm_norm),
    .meta_i (norm_meta),
    .root_o (root),
    .sm_o   (sm_sqrt),
    .meta_o (sqrt_meta)
  );

  tun_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .root_i  (root),
    .sm_i    (sm_sqrt),
    .meta_i  (sqrt_meta),
    .nrm_o   (nrm),
    .degen_o (degenerate_o),
    .valid_o (done_o)
  );

  assign nrm_x_o = nrm[0];
  assign nrm_y_o = nrm[1];
  assign nrm_z_o = nrm[2];

endmodule

@@ sv/tun_checker.sv @@
// Port-level checks for triangle_unit_normal, and the bind that attaches them.
// Depends on tun_pkg and triangle_unit_normal.
module tun_checker #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic [tun_pkg::OUT_WIDTH-1:0] nrm_x_o,
  input logic [tun_pkg::OUT_WIDTH-1:0] nrm_y_o,
  input logic [tun_pkg::OUT_WIDTH-1:0] nrm_z_o,
  input logic                          degenerate_o
);
  import tun_pkg::*;

  localparam int LATENCY = NORMAL_FRAC_BITS + 40;

  // every result traces back to a word taken a fixed time earlier
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching start");

  a_flag_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    degenerate_o |-> done_o)
    else $error("degenerate flag outside a result");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (nrm_x_o == '0 && nrm_y_o == '0 && nrm_z_o == '0))
    else $error("degenerate result with non-zero normal");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !busy)
    else $error("pipeline raised busy");

endmodule

bind triangle_unit_normal tun_checker #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .nrm_x_o      (nrm_x_o),
  .nrm_y_o      (nrm_y_o),
  .nrm_z_o      (nrm_z_o),
  .degenerate_o (degenerate_o)
);
